>>> hw/rtl/dmts_pkg.sv
// Shared types, constants and register codes for the dual motor throttle supervisor.
// No dependencies; every other file but the checker refers to this package by scoped names.
`default_nettype none

package dmts_pkg;

    localparam int NUM_LANES = 2;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [REG_IDX_W-1:0] REG_ESTOP_TIMEOUT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DESYNC_ENABLE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DESYNC_TIME   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_REVERSE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_REVERSE = 3'd5;

    localparam logic [15:0] ESTOP_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] SEND_INTERVAL_RST = 16'd1000;
    localparam logic [15:0] DESYNC_TIME_RST   = 16'd500;

    localparam logic [31:0] DESYNC_ERPM = 32'd63000;
    localparam logic signed [15:0] NEAR_ZERO_Q15 = 16'sd32;

    localparam logic [10:0] REV_MIN    = 11'd50;
    localparam logic [10:0] FWD_MIN    = 11'd1050;
    localparam logic [9:0]  THR_SPAN   = 10'd950;
    localparam logic signed [15:0] CMD_MIN = 16'sh8000;
    localparam logic signed [15:0] CMD_MAX = 16'sh7fff;

    typedef struct packed {
        logic [15:0] estop_timeout_ms;
        logic [15:0] send_interval_us;
        logic        desync_enable;
        logic [15:0] desync_time_ms;
        logic        left_reverse;
        logic        right_reverse;
    } cfg_t;

    // What one lane reports to the merging control for desync detection.
    typedef struct packed {
        logic near_zero;
        logic erpm_high;
    } lane_flag_t;

    // Pipeline advance strobes and the first-stage send flag from the control to the lanes.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s1_sent;
    } pipe_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dual_motor_throttle_supervisor_top.sv
// Top level of the dual motor throttle supervisor: register file, control and two lanes.
// Depends on dmts_pkg, dmts_regs, dmts_lane and dmts_ctrl.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    time_ms time_us last_signal_ms left/right_command,
//                                    left/right_erpm
//   output    out_valid / out_ready  sent left/right_throttle estop_active desync_fault
//                                    left/right_speed
//   config    psel penable pwrite    paddr pwdata prdata pready
//
// A word is accepted every cycle unless a stall holds a full first stage.
// The send, estop and desync decisions and state update finish in the first stage;
// the throttle multiply by 950 in each lane fills the second stage.
// Reset clears the desync state, the send timestamp and the pipeline valids.
// A stalled output holds its word; the first stage keeps accepting while it is empty.
`default_nettype none

module dual_motor_throttle_supervisor_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dmts_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [31:0]                   time_ms,
    input  wire logic [31:0]                   time_us,
    input  wire logic [31:0]                   last_signal_ms,
    input  wire logic signed [15:0]            left_command,
    input  wire logic signed [15:0]            right_command,
    input  wire logic [31:0]                   left_erpm,
    input  wire logic [31:0]                   right_erpm,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               sent,
    output logic [10:0]                        left_throttle,
    output logic [10:0]                        right_throttle,
    output logic                               estop_active,
    output logic                               desync_fault,
    output logic [31:0]                        left_speed,
    output logic [31:0]                        right_speed
);

    dmts_pkg::cfg_t       cfg;
    dmts_pkg::pipe_ctl_t  ctl;
    dmts_pkg::lane_flag_t flag [dmts_pkg::NUM_LANES];
    logic                 estop;

    dmts_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmts_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .time_ms        (time_ms),
        .time_us        (time_us),
        .last_signal_ms (last_signal_ms),
        .flag           (flag),
        .estop          (estop),
        .ctl            (ctl),
        .sent           (sent),
        .estop_active   (estop_active),
        .desync_fault   (desync_fault)
    );

    dmts_lane u_lane_left
    (
        .clk      (clk),
        .ctl      (ctl),
        .estop    (estop),
        .reverse  (cfg.left_reverse),
        .command  (left_command),
        .erpm     (left_erpm),
        .flag     (flag[0]),
        .throttle (left_throttle),
        .speed    (left_speed)
    );

    dmts_lane u_lane_right
    (
        .clk      (clk),
        .ctl      (ctl),
        .estop    (estop),
        .reverse  (cfg.right_reverse),
        .command  (right_command),
        .erpm     (right_erpm),
        .flag     (flag[1]),
        .throttle (right_throttle),
        .speed    (right_speed)
    );

endmodule

`default_nettype wire

>>> hw/rtl/dmts_regs.sv
// Configuration register file on an APB-style port.
// Depends on dmts_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module dmts_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dmts_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output dmts_pkg::cfg_t                     cfg
);

    dmts_pkg::cfg_t                      cfg_reg;
    logic                                wr_en;
    logic [dmts_pkg::REG_IDX_W-1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[dmts_pkg::PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.estop_timeout_ms <= dmts_pkg::ESTOP_TIMEOUT_RST;
            cfg_reg.send_interval_us <= dmts_pkg::SEND_INTERVAL_RST;
            cfg_reg.desync_enable    <= 1'b1;
            cfg_reg.desync_time_ms   <= dmts_pkg::DESYNC_TIME_RST;
            cfg_reg.left_reverse     <= 1'b0;
            cfg_reg.right_reverse    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                dmts_pkg::REG_ESTOP_TIMEOUT: cfg_reg.estop_timeout_ms <= pwdata[15:0];
                dmts_pkg::REG_SEND_INTERVAL: cfg_reg.send_interval_us <= pwdata[15:0];
                dmts_pkg::REG_DESYNC_ENABLE: cfg_reg.desync_enable    <= pwdata[0];
                dmts_pkg::REG_DESYNC_TIME:   cfg_reg.desync_time_ms   <= pwdata[15:0];
                dmts_pkg::REG_LEFT_REVERSE:  cfg_reg.left_reverse     <= pwdata[0];
                dmts_pkg::REG_RIGHT_REVERSE: cfg_reg.right_reverse    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dmts_pkg::REG_ESTOP_TIMEOUT: prdata = {16'd0, cfg_reg.estop_timeout_ms};
            dmts_pkg::REG_SEND_INTERVAL: prdata = {16'd0, cfg_reg.send_interval_us};
            dmts_pkg::REG_DESYNC_ENABLE: prdata = {31'd0, cfg_reg.desync_enable};
            dmts_pkg::REG_DESYNC_TIME:   prdata = {16'd0, cfg_reg.desync_time_ms};
            dmts_pkg::REG_LEFT_REVERSE:  prdata = {31'd0, cfg_reg.left_reverse};
            dmts_pkg::REG_RIGHT_REVERSE: prdata = {31'd0, cfg_reg.right_reverse};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/dmts_lane.sv
// One motor lane: estop zeroing, direction flag, throttle mapping and speed passthrough.
// Depends on dmts_pkg for constants and the lane_flag_t and pipe_ctl_t structs.
`default_nettype none

module dmts_lane
(
    input  wire logic                clk,
    input  wire dmts_pkg::pipe_ctl_t ctl,
    input  wire logic                estop,
    input  wire logic                reverse,
    input  wire logic signed [15:0]  command,
    input  wire logic [31:0]         erpm,
    output dmts_pkg::lane_flag_t     flag,
    output logic [10:0]              throttle,
    output logic [31:0]              speed
);

    logic signed [15:0] cmd_z;
    logic signed [15:0] cmd_dir;
    logic signed [15:0] cmd_reg;
    logic [31:0]        erpm_reg;
    logic [15:0]        mag;
    logic [25:0]        prod;
    logic [10:0]        thr_map;
    logic [10:0]        throttle_reg;
    logic [31:0]        speed_reg;

    // Stage one: the near-zero test looks at the command before the direction flag.
    always_comb
    begin
        cmd_z          = estop ? 16'sd0 : command;
        flag.near_zero = (cmd_z >= -dmts_pkg::NEAR_ZERO_Q15) &&
                         (cmd_z <= dmts_pkg::NEAR_ZERO_Q15);
        flag.erpm_high = erpm > dmts_pkg::DESYNC_ERPM;
        if (!reverse)
            cmd_dir = cmd_z;
        else if (cmd_z == dmts_pkg::CMD_MIN)
            cmd_dir = dmts_pkg::CMD_MAX;
        else
            cmd_dir = -cmd_z;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            cmd_reg  <= cmd_dir;
            erpm_reg <= erpm;
        end
    end

    // Stage two: magnitude times 950, top bits give the step within the band.
    always_comb
    begin
        mag  = cmd_reg[15] ? (16'd0 - $unsigned(cmd_reg)) : $unsigned(cmd_reg);
        prod = 26'(mag) * 26'(dmts_pkg::THR_SPAN);
        if (cmd_reg == 16'sd0)
            thr_map = 11'd0;
        else if (cmd_reg[15])
            thr_map = dmts_pkg::REV_MIN + prod[25:15];
        else
            thr_map = dmts_pkg::FWD_MIN + prod[25:15];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            throttle_reg <= ctl.s1_sent ? thr_map : 11'd0;
            speed_reg    <= erpm_reg;
        end
    end

    assign throttle = throttle_reg;
    assign speed    = speed_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dmts_ctrl.sv
// Merging control: estop and send decisions, desync tracking state and pipeline handshake.
// Depends on dmts_pkg for cfg_t, lane_flag_t and pipe_ctl_t.
`default_nettype none

module dmts_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dmts_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire logic [31:0]           time_ms,
    input  wire logic [31:0]           time_us,
    input  wire logic [31:0]           last_signal_ms,
    input  wire dmts_pkg::lane_flag_t  flag [dmts_pkg::NUM_LANES],
    output logic                       estop,
    output dmts_pkg::pipe_ctl_t        ctl,
    output logic                       sent,
    output logic                       estop_active,
    output logic                       desync_fault
);

    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        s1_sent_reg;
    logic        s1_estop_reg;
    logic        s1_fault_reg;
    logic        sent_reg;
    logic        estop_reg;
    logic        fault_out_reg;

    logic [31:0] last_send_us_reg;
    logic [31:0] last_send_us_next;
    logic        pending_reg;
    logic        pending_next;
    logic [31:0] start_ms_reg;
    logic [31:0] start_ms_next;
    logic        fault_reg;
    logic        fault_next;

    logic        s1_en;
    logic        s2_en;
    logic        accept;
    logic [31:0] age_ms;
    logic [31:0] gap_us;
    logic [31:0] since_ms;
    logic        send;
    logic        cond;
    logic        check;

    assign s2_en    = !out_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;
    assign accept   = in_valid && s1_en;

    assign ctl.s1_en   = s1_en;
    assign ctl.s2_en   = s2_en;
    assign ctl.s1_sent = s1_sent_reg;

    always_comb
    begin
        age_ms   = time_ms - last_signal_ms;
        gap_us   = time_us - last_send_us_reg;
        since_ms = time_ms - start_ms_reg;
        estop    = age_ms > {16'd0, cfg.estop_timeout_ms};
        send     = !fault_reg && (gap_us >= {16'd0, cfg.send_interval_us});
        cond     = (flag[0].near_zero && flag[0].erpm_high) ||
                   (flag[1].near_zero && flag[1].erpm_high);
        check    = send && cfg.desync_enable;

        last_send_us_next = send ? time_us : last_send_us_reg;
        pending_next      = pending_reg;
        start_ms_next     = start_ms_reg;
        fault_next        = fault_reg;
        if (check)
        begin
            if (cond)
            begin
                pending_next = 1'b1;
                // A fresh start makes the elapsed time zero, so only a pending run can fault.
                if (!pending_reg)
                    start_ms_next = time_ms;
                else if (since_ms > {16'd0, cfg.desync_time_ms})
                    fault_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_send_us_reg <= 32'd0;
            pending_reg      <= 1'b0;
            start_ms_reg     <= 32'd0;
            fault_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_send_us_reg <= last_send_us_next;
                pending_reg      <= pending_next;
                start_ms_reg     <= start_ms_next;
                fault_reg        <= fault_next;
            end
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_sent_reg  <= send;
            s1_estop_reg <= estop;
            s1_fault_reg <= fault_next;
        end
        if (s2_en)
        begin
            sent_reg      <= s1_sent_reg;
            estop_reg     <= s1_estop_reg;
            fault_out_reg <= s1_fault_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sent         = sent_reg;
    assign estop_active = estop_reg;
    assign desync_fault = fault_out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dmts_checker.sv
// Port-level checks for the dual motor throttle supervisor, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module dmts_sva
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        sent,
    input wire logic [10:0] left_throttle,
    input wire logic [10:0] right_throttle,
    input wire logic        estop_active,
    input wire logic        desync_fault
);

    // A word that is not taken stays put with its throttle codes.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_throttle)
                                    && $stable(right_throttle))
        else $error("output word changed while stalled");

    // Nothing sent means both throttle codes read as stop.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sent |-> left_throttle == 11'd0 && right_throttle == 11'd0)
        else $error("throttle nonzero on a word that sent nothing");

    // A signal timeout zeroes both commands, so the codes must be stop.
    a_estop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && estop_active |-> left_throttle == 11'd0 && right_throttle == 11'd0)
        else $error("throttle nonzero during estop");

    // The left throttle code stays inside the stop, reverse and forward bands.
    a_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_throttle == 11'd0 ||
                       (left_throttle >= 11'd50 && left_throttle <= 11'd1000) ||
                       (left_throttle >= 11'd1050 && left_throttle <= 11'd2000)))
        else $error("left throttle outside its bands");

    // The fault latch only clears on reset, so it shows on every later word.
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && desync_fault |=> !out_valid || desync_fault)
        else $error("desync fault dropped without reset");

endmodule

bind dual_motor_throttle_supervisor_top dmts_sva u_dmts_sva
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sent           (sent),
    .left_throttle  (left_throttle),
    .right_throttle (right_throttle),
    .estop_active   (estop_active),
    .desync_fault   (desync_fault)
);

`default_nettype wire
